/* rtl/b64x_pkg.sv */
// ----------------------------------------------------------------------------
// b64x_pkg
// Shared types, constants and the keyed alphabet for the Base64 line encoder.
// ----------------------------------------------------------------------------
package b64x_pkg;

    localparam int unsigned LINE_CHARS_DEFAULT = 76;

    localparam logic [7:0] XOR_KEY_RESET        = 8'd250;
    localparam logic       NEWLINE_ENABLE_RESET = 1'b1;

    localparam logic [7:0] PAD_CHAR     = 8'd61;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_XOR_KEY        = 1'b0,
        REG_NEWLINE_ENABLE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    // one byte's worth of characters, handed from the encoder core
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      count;
        logic            last;
    } group_t;

    // map a sextet to the standard alphabet and apply the key
    function automatic logic [7:0] keyed_char(input logic [5:0] sextet, input logic [7:0] key);
        logic [7:0] c;
        if (sextet < 6'd26)
            c = 8'd65 + {2'b00, sextet};
        else if (sextet < 6'd52)
            c = 8'd71 + {2'b00, sextet};
        else if (sextet < 6'd62)
            c = {2'b00, sextet} - 8'd4;
        else if (sextet == 6'd62)
            c = 8'd43;
        else
            c = 8'd47;
        return c ^ key;
    endfunction

endpackage

/* rtl/b64x_core.sv */
// ----------------------------------------------------------------------------
// b64x_core
// Byte phase, leftover bits and line group count; builds the characters
// that one byte produces.
// ----------------------------------------------------------------------------
module b64x_core #(
    parameter int unsigned LINE_CHARS = b64x_pkg::LINE_CHARS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  b64x_pkg::in_item_t item,
    input  logic [7:0]         xor_key,
    input  logic               newline_enable,
    output b64x_pkg::group_t   group
);

    // groups until the character count is a multiple of LINE_CHARS
    localparam int unsigned WRAP_GROUPS = (LINE_CHARS % 4 == 0) ? LINE_CHARS / 4 :
                                          (LINE_CHARS % 2 == 0) ? LINE_CHARS / 2 :
                                          LINE_CHARS;
    localparam int unsigned GRP_W = $clog2(WRAP_GROUPS + 1);

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    logic [1:0]       phase_reg,  phase_next;
    logic [3:0]       carry_reg,  carry_next;
    logic [GRP_W-1:0] groups_reg, groups_next;
    logic [GRP_W-1:0] groups_inc;
    logic [7:0]       b;

    assign b          = item.data_byte;
    assign groups_inc = groups_reg + GRP_W'(1);

    always_comb
    begin
        group.chars = '0;
        group.count = 3'd1;
        group.last  = item.last_byte;
        phase_next  = phase_reg;
        carry_next  = carry_reg;
        groups_next = groups_reg;
        unique case (phase_reg)
            PHASE_1:
            begin
                group.chars[0] = b64x_pkg::keyed_char({carry_reg[1:0], b[7:4]}, xor_key);
                phase_next     = PHASE_2;
                carry_next     = b[3:0];
                if (item.last_byte)
                begin
                    group.chars[1] = b64x_pkg::keyed_char({b[3:0], 2'b00}, xor_key);
                    group.chars[2] = b64x_pkg::PAD_CHAR;
                    group.count    = 3'd3;
                end
            end
            PHASE_2:
            begin
                group.chars[0] = b64x_pkg::keyed_char({carry_reg, b[7:6]}, xor_key);
                group.chars[1] = b64x_pkg::keyed_char(b[5:0], xor_key);
                group.count    = 3'd2;
                phase_next     = PHASE_0;
                carry_next     = 4'd0;
                groups_next    = groups_inc;
                if (groups_inc == GRP_W'(WRAP_GROUPS))
                begin
                    groups_next = '0;
                    if (newline_enable)
                    begin
                        group.chars[2] = b64x_pkg::NEWLINE_CHAR;
                        group.count    = 3'd3;
                    end
                end
            end
            default:
            begin
                group.chars[0] = b64x_pkg::keyed_char(b[7:2], xor_key);
                phase_next     = PHASE_1;
                carry_next     = {2'b00, b[1:0]};
                if (item.last_byte)
                begin
                    group.chars[1] = b64x_pkg::keyed_char({b[1:0], 4'b0000}, xor_key);
                    group.chars[2] = b64x_pkg::PAD_CHAR;
                    group.chars[3] = b64x_pkg::PAD_CHAR;
                    group.count    = 3'd4;
                end
            end
        endcase
        // end of message: start the next one clean
        if (item.last_byte)
        begin
            phase_next  = PHASE_0;
            carry_next  = 4'd0;
            groups_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_0;
            carry_reg  <= 4'd0;
            groups_reg <= '0;
        end
        else if (load)
        begin
            phase_reg  <= phase_next;
            carry_reg  <= carry_next;
            groups_reg <= groups_next;
        end
    end

endmodule

/* rtl/base64_xor_line_encoder.sv */
// ----------------------------------------------------------------------------
// base64_xor_line_encoder
// Streaming Base64 encoder with a keyed alphabet and optional line breaks.
// ----------------------------------------------------------------------------
// Usage:
//   src channel: one raw byte per transfer (data_byte, last_byte), valid/stall.
//   dst channel: one character per transfer (out_char, out_last), valid/stall.
//   Each byte yields one to four characters: one alphabet character normally,
//   two when it closes a three-byte group (three if a newline follows), and
//   three or four when last_byte flushes a padded partial group. out_last
//   marks the final character of the message.
//   The characters of a byte pass from the hold register into the group
//   buffer before they are offered on dst.
//   The output side moves one character per cycle while dst does not
//   stall; the group buffer drain is the limit. A new byte is taken in the
//   cycle the buffer hands over its final character, so bytes making one
//   character stream at one per cycle while dst does not stall.
//   Stall on dst holds the current character; src stalls once the hold
//   register is full and the group buffer cannot take it.
//   Reset clears the phase, leftover bits and group count, empties both
//   registers, and loads xor_key = 250 and newline_enable = 1.
//   Configuration writes (cfg_we, cfg_idx, cfg_wdata) take effect at once
//   and are meant to happen only while the encoder is idle.
// ----------------------------------------------------------------------------
module base64_xor_line_encoder #(
    parameter int unsigned LINE_CHARS = b64x_pkg::LINE_CHARS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           src_valid,
    output logic                           src_stall,
    input  b64x_pkg::in_item_t             src_data,
    output logic                           dst_valid,
    input  logic                           dst_stall,
    output b64x_pkg::out_item_t            dst_data,
    input  logic                           cfg_we,
    input  logic [b64x_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [7:0]                     cfg_wdata
);

    // configuration
    logic [7:0] xor_key_reg;
    logic       nl_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg <= b64x_pkg::XOR_KEY_RESET;
            nl_en_reg   <= b64x_pkg::NEWLINE_ENABLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (b64x_pkg::cfg_reg_t'(cfg_idx))
                b64x_pkg::REG_XOR_KEY:        xor_key_reg <= cfg_wdata;
                b64x_pkg::REG_NEWLINE_ENABLE: nl_en_reg   <= cfg_wdata[0];
            endcase
        end
    end

    // input hold register
    logic               hold_valid_reg;
    b64x_pkg::in_item_t hold_item_reg;

    // group buffer: characters of one byte, drained one per cycle unless dst stalls
    logic [3:0][7:0] buf_chars_reg;
    logic [2:0]      buf_cnt_reg;
    logic [1:0]      buf_idx_reg;
    logic            buf_last_reg;

    b64x_pkg::group_t group;

    logic take;
    logic buf_free;
    logic load;
    logic accept;

    assign dst_valid = (buf_cnt_reg != 3'd0);
    assign take      = dst_valid && !dst_stall;
    // buffer is free when empty or handing over its final character now
    assign buf_free  = !dst_valid || (take && buf_cnt_reg == 3'd1);
    assign load      = hold_valid_reg && buf_free;
    assign src_stall = hold_valid_reg && !buf_free;
    assign accept    = src_valid && !src_stall;

    assign dst_data.out_char = buf_chars_reg[buf_idx_reg];
    assign dst_data.out_last = buf_last_reg && (buf_cnt_reg == 3'd1);

    b64x_core #(
        .LINE_CHARS(LINE_CHARS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .item          (hold_item_reg),
        .xor_key       (xor_key_reg),
        .newline_enable(nl_en_reg),
        .group         (group)
    );

    // hold register: fill on transfer, drain on load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (accept)
                hold_valid_reg <= 1'b1;
            else if (load)
                hold_valid_reg <= 1'b0;
            else
                hold_valid_reg <= hold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_item_reg <= src_data;
    end

    // group buffer control: load a new group or advance past a taken char
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_cnt_reg <= 3'd0;
            buf_idx_reg <= 2'd0;
        end
        else
        begin
            priority if (load)
            begin
                buf_cnt_reg <= group.count;
                buf_idx_reg <= 2'd0;
            end
            else if (take)
            begin
                buf_cnt_reg <= buf_cnt_reg - 3'd1;
                buf_idx_reg <= buf_idx_reg + 2'd1;
            end
            else
            begin
                buf_cnt_reg <= buf_cnt_reg;
                buf_idx_reg <= buf_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_chars_reg <= group.chars;
            buf_last_reg  <= group.last;
        end
    end

endmodule

/* tb/sv/base64_xor_line_encoder_tb.sv */
// ----------------------------------------------------------------------------
// base64_xor_line_encoder_tb
// Self-checking bench for the keyed Base64 line encoder. A behavioral encoder
// in the bench predicts every character of each byte transfer. A checker
// compares each character transfer with the oldest prediction. Directed
// messages cover padding, key extremes and mid-message key changes. Random
// messages cover line breaks and random configurations. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module base64_xor_line_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_LEN       = b64x_pkg::LINE_CHARS_DEFAULT;
    localparam int          BYTES_PER_LINE = (LINE_LEN / 4) * 3;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam logic [7:0]  KEY_AT_RESET   = 8'd250;
    localparam logic        NL_AT_RESET    = 1'b1;
    localparam logic [7:0]  PAD            = "=";
    localparam logic [7:0]  LINE_FEED      = 8'h0A;

    // Standard alphabet, sextet 0 in the top byte.
    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    b64x_pkg::in_item_t   src_data  = '0;
    logic                 dst_valid;
    logic                 dst_stall = 1'b0;
    b64x_pkg::out_item_t  dst_data;
    logic                 cfg_we    = 1'b0;
    logic [b64x_pkg::CFG_IDX_W-1:0] cfg_idx = b64x_pkg::REG_XOR_KEY;
    logic [7:0]           cfg_wdata = 8'd0;

    // Encoder state mirrored in the bench.
    logic [7:0]  enc_key;
    logic        enc_nl_en;
    logic [1:0]  enc_phase;
    logic [3:0]  enc_carry;
    int          enc_groups;

    b64x_pkg::out_item_t expected_chars[$];
    int          mismatches = 0;
    int          cycles     = 0;
    bit          no_idle    = 1'b0;   // set to suppress idling on both sides

    base64_xor_line_encoder #(.LINE_CHARS(LINE_LEN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycles, expected_chars.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stall the character channel about 6 times in a hundred.
    always @(posedge clk)
    begin
        dst_stall <= !no_idle && ($urandom_range(99) < 6);
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic [7:0] keyed(input logic [5:0] sextet);
        int idx;
        idx = 63 - int'(sextet);
        return ALPHABET[idx*8 +: 8] ^ enc_key;
    endfunction

    // Encode one accepted byte and queue the characters it produces.
    function automatic void encode_byte(input logic [7:0] b, input logic l);
        logic [7:0]          seq[$];
        b64x_pkg::out_item_t item;
        case (enc_phase)
            2'd1:
            begin
                seq.push_back(keyed({enc_carry[1:0], b[7:4]}));
                enc_carry = b[3:0];
                enc_phase = 2'd2;
                if (l)
                begin
                    seq.push_back(keyed({b[3:0], 2'b00}));
                    seq.push_back(PAD);
                end
            end
            2'd2:
            begin
                seq.push_back(keyed({enc_carry, b[7:6]}));
                seq.push_back(keyed(b[5:0]));
                enc_carry = 4'd0;
                enc_phase = 2'd0;
                enc_groups++;
                // The group count wraps at the line end even with breaks off.
                if ((enc_groups * 4) % LINE_LEN == 0)
                begin
                    enc_groups = 0;
                    if (enc_nl_en)
                        seq.push_back(LINE_FEED);
                end
            end
            default:
            begin
                seq.push_back(keyed(b[7:2]));
                enc_carry = {2'b00, b[1:0]};
                enc_phase = 2'd1;
                if (l)
                begin
                    seq.push_back(keyed({b[1:0], 4'b0000}));
                    seq.push_back(PAD);
                    seq.push_back(PAD);
                end
            end
        endcase
        // The final character of a message, a line feed included, is marked.
        foreach (seq[i])
        begin
            item.out_char = seq[i];
            item.out_last = l && (i == seq.size() - 1);
            expected_chars.push_back(item);
        end
        if (l)
        begin
            enc_phase  = 2'd0;
            enc_carry  = 4'd0;
            enc_groups = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking: compare each character transfer with the oldest prediction.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        b64x_pkg::out_item_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected character %02h last %0b",
                             dst_data.out_char, dst_data.out_last);
                mismatches++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (dst_data.out_char !== want.out_char ||
                    dst_data.out_last !== want.out_last)
                begin
                    if (mismatches < 10)
                        $display("char mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.out_char, want.out_last,
                                 dst_data.out_char, dst_data.out_last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Offer one byte, hold it until the transfer, then predict its characters.
    // Valid stays high afterwards so back-to-back bytes need no second edit.
    task automatic send_byte(input logic [7:0] b, input logic l);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 6)
            begin
                src_valid <= 1'b0;
                @(posedge clk);
            end
        end
        src_valid <= 1'b1;
        src_data.data_byte <= b;
        src_data.last_byte <= l;
        do
            @(posedge clk);
        while (src_stall);
        encode_byte(b, l);
    endtask

    // Drop valid and hold off until every predicted character has arrived.
    task automatic drain();
        src_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write the key register, then the newline-enable register; call only while idle.
    task automatic write_cfg(input logic [7:0] key, input logic nl_en);
        cfg_we    <= 1'b1;
        cfg_idx   <= b64x_pkg::REG_XOR_KEY;
        cfg_wdata <= key;
        @(posedge clk);
        enc_key = key;
        cfg_idx   <= b64x_pkg::REG_NEWLINE_ENABLE;
        cfg_wdata <= {7'd0, nl_en};
        @(posedge clk);
        enc_nl_en = nl_en;
        cfg_we <= 1'b0;
    endtask

    // Send a message of random bytes; optionally pause before byte pause_at
    // until the encoder has emptied out.
    task automatic send_message(input int len, input int pause_at);
        for (int i = 0; i < len; i++)
        begin
            if (i == pause_at)
                drain();
            send_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Encode with the reset key and line breaks, one-byte messages at extremes.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain();
    endtask

    // Cover each flush phase and a full group at both key extremes.
    task automatic test_partial_groups();
        write_cfg(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);          // two-byte tail, one pad
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);          // full group, no pad
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);          // one-byte tail after a group
        drain();
        write_cfg(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 5; i++)
            send_byte(8'hFF, i == 4);
        drain();
    endtask

    // Change the key between bytes of one message; it applies from then on.
    task automatic test_config_mid_message();
        write_cfg(8'hA5, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        drain();
        write_cfg(8'h5A, 1'b1);
        send_byte(8'h56, 1'b1);
        drain();
    endtask

    // Reach line ends: a break that ends the message, a wrap with breaks
    // off, and two lines back to back with no idling at all.
    task automatic test_line_breaks();
        write_cfg(8'($urandom_range(255)), 1'b1);
        send_message(BYTES_PER_LINE, BYTES_PER_LINE / 2);
        drain();
        write_cfg(8'($urandom_range(255)), 1'b0);
        send_message(BYTES_PER_LINE + 1, -1);
        drain();
        write_cfg(8'($urandom_range(255)), 1'b1);
        no_idle = 1'b1;
        send_message(2 * BYTES_PER_LINE, -1);
        drain();
        no_idle = 1'b0;
    endtask

    // Short random messages with random keys and break settings.
    task automatic test_random_messages();
        int sent;
        int len;
        logic [7:0] key;
        sent = 0;
        while (sent < 55)
        begin
            if ($urandom_range(3) == 0)
            begin
                drain();
                case ($urandom_range(3))
                    0:       key = 8'h00;
                    1:       key = 8'hFF;
                    default: key = 8'($urandom_range(255));
                endcase
                write_cfg(key, 1'($urandom_range(1)));
            end
            len = $urandom_range(12, 1);
            // Now and then stop mid-message until the output side catches up.
            send_message(len, ($urandom_range(7) == 0) ? $urandom_range(len - 1) : -1);
            sent += len;
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        enc_key    = KEY_AT_RESET;
        enc_nl_en  = NL_AT_RESET;
        enc_phase  = 2'd0;
        enc_carry  = 4'd0;
        enc_groups = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_partial_groups();
        test_config_mid_message();
        test_line_breaks();
        test_random_messages();

        // Let any stray character show up before the verdict.
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
